FILE: hw/rtl/rch_pkg.sv
`default_nettype none
package rch_pkg;

	// heap size, derived widths and fixed link and count widths
	localparam int CELLS = 4096;
	localparam int IDX_W = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int LINK_W = 12;
	localparam int REFS_W = 13;
	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	// request codes
	typedef enum logic [1:0] {
		REQ_CONS = 2'd0,
		REQ_ADD  = 2'd1,
		REQ_DROP = 2'd2,
		REQ_READ = 2'd3
	} req_code_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [LINK_W-1:0] target_cell;
		logic              target_null;
		logic [LINK_W-1:0] new_head;
		logic              new_head_null;
		logic [LINK_W-1:0] new_tail;
		logic              new_tail_null;
	} req_t;

	typedef struct packed {
		logic [LINK_W-1:0] made_cell;
		logic              out_of_memory;
		logic [LINK_W-1:0] cell_head;
		logic              cell_head_null;
		logic [LINK_W-1:0] cell_tail;
		logic              cell_tail_null;
		logic [REFS_W-1:0] cell_refs;
		logic [REFS_W-1:0] total_refs;
	} rsp_t;

	// one stored link: null flag plus index
	typedef struct packed {
		logic              nul;
		logic [LINK_W-1:0] idx;
	} link_t;

	// one heap entry as held in memory
	typedef struct packed {
		logic [REFS_W-1:0] refs;
		link_t             head;
		link_t             tail;
	} entry_t;

	localparam link_t LINK_NULL = '{nul: 1'b1, idx: '0};

endpackage
`default_nettype wire

FILE: hw/rtl/rch_req_if.sv
`default_nettype none
interface rch_req_if;
	logic          valid;
	logic          ready;
	rch_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rch_rsp_if.sv
`default_nettype none
interface rch_rsp_if;
	logic          valid;
	logic          ready;
	rch_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rch_ram.sv
`default_nettype none
module rch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/refcount_cell_heap_top.sv
`default_nettype none
// Reference-counted pair-cell heap. All cells live in one memory word each
// (count, head link, tail link); after reset a clearing pass over all CELLS
// words runs before the first word is taken. Add and drop do one
// read-modify-write plus a report read; a read does the report read alone;
// all three go straight to the result when the target is null. A cons
// writes the prepared slot, does
// one read-modify-write per non-null link, then scans the memory for the next
// zero-count cell at one cell per cycle, releases that cell's old children
// with up to two more read-modify-writes and reads the new cell back. A cons
// that follows a failed search scans first, and reports out of memory if
// that scan finds nothing. The single memory port pair serialises all of
// these steps. A finished result waits in an output register while the
// next word is taken.
module refcount_cell_heap_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rch_req_if.sink     req,
	rch_rsp_if.source   rsp
);

	localparam int IW = rch_pkg::IDX_W;
	localparam int CW = rch_pkg::CNT_W;

	typedef enum logic [8:0] {
		ST_CLEAR   = 9'b000000001,
		ST_IDLE    = 9'b000000010,
		ST_ADJ_RD  = 9'b000000100,
		ST_ADJ_WR  = 9'b000001000,
		ST_SCAN    = 9'b000010000,
		ST_MAKE    = 9'b000100000,
		ST_REP_RD  = 9'b001000000,
		ST_REP_DAT = 9'b010000000,
		ST_FIN     = 9'b100000000
	} state_t;

	// what an adjust step returns to
	typedef enum logic [2:0] {
		STEP_TGT,
		STEP_MK_H,
		STEP_MK_T,
		STEP_REL_H,
		STEP_REL_T
	} step_t;

	state_t              state_q, state_d;
	step_t               step_q, step_d;
	rch_pkg::req_t       req_q;
	logic [IW-1:0]       slot_q, slot_d;
	logic                slot_ok_q, slot_ok_d;
	logic                pre_q, pre_d;
	logic                oom_q, oom_d;
	logic [rch_pkg::REFS_W-1:0] total_q, total_d;
	logic [IW-1:0]       adj_addr_q, adj_addr_d;
	logic                adj_inc_q, adj_inc_d;
	rch_pkg::link_t      rel_tail_q, rel_tail_d;
	logic [IW-1:0]       found_q, found_d;
	logic [IW-1:0]       rep_addr_q, rep_addr_d;
	logic [IW-1:0]       clr_q, clr_d;
	logic [IW-1:0]       scan_addr_q, scan_addr_d;
	logic [CW-1:0]       scan_left_q, scan_left_d;
	logic                chk_vld_s1, chk_vld_d;
	logic [IW-1:0]       chk_addr_s1;
	rch_pkg::rsp_t       res_q, res_d;
	rch_pkg::rsp_t       out_q;
	logic                out_vld_q;

	logic                we;
	logic [IW-1:0]       waddr, raddr;
	rch_pkg::entry_t     wdata, rdata;

	rch_pkg::link_t      mk_head, mk_tail;
	logic                tgt_null;
	logic                go_after_rel, go_post_scan;
	logic                take;

	// cons links: null flag or out-of-range index stores as null
	always_comb begin
		mk_head = rch_pkg::LINK_NULL;
		mk_tail = rch_pkg::LINK_NULL;
		if (!req_q.new_head_null && (32'(req_q.new_head) < 32'(rch_pkg::CELLS))) begin
			mk_head = '{nul: 1'b0, idx: req_q.new_head};
		end
		if (!req_q.new_tail_null && (32'(req_q.new_tail) < 32'(rch_pkg::CELLS))) begin
			mk_tail = '{nul: 1'b0, idx: req_q.new_tail};
		end
	end

	assign tgt_null = req_q.target_null || (32'(req_q.target_cell) >= 32'(rch_pkg::CELLS));
	assign take = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// sequencer
	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		slot_d       = slot_q;
		slot_ok_d    = slot_ok_q;
		pre_d        = pre_q;
		oom_d        = oom_q;
		total_d      = total_q;
		adj_addr_d   = adj_addr_q;
		adj_inc_d    = adj_inc_q;
		rel_tail_d   = rel_tail_q;
		found_d      = found_q;
		rep_addr_d   = rep_addr_q;
		clr_d        = clr_q;
		scan_addr_d  = scan_addr_q;
		scan_left_d  = scan_left_q;
		chk_vld_d    = 1'b0;
		res_d        = res_q;
		we           = 1'b0;
		waddr        = adj_addr_q;
		wdata        = rdata;
		raddr        = adj_addr_q;
		go_after_rel = 1'b0;
		go_post_scan = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '{refs: '0, head: rch_pkg::LINK_NULL, tail: rch_pkg::LINK_NULL};
				clr_d = clr_q + 1'b1;
				if (clr_q == IW'(rch_pkg::CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (take) begin
					oom_d = 1'b0;
					res_d = '0;
					res_d.cell_head_null = 1'b1;
					res_d.cell_tail_null = 1'b1;
					case (req.data.req_type)
						rch_pkg::REQ_CONS: begin
							if (slot_ok_q) begin
								state_d = ST_MAKE;
							end else begin
								// earlier search failed: search again first
								pre_d       = 1'b1;
								scan_addr_d = (slot_q == IW'(rch_pkg::CELLS - 1)) ?
								              '0 : slot_q + 1'b1;
								scan_left_d = CW'(rch_pkg::CELLS - 1);
								state_d     = ST_SCAN;
							end
						end
						rch_pkg::REQ_ADD, rch_pkg::REQ_DROP: begin
							adj_inc_d  = (req.data.req_type == rch_pkg::REQ_ADD);
							adj_addr_d = IW'(req.data.target_cell);
							rep_addr_d = IW'(req.data.target_cell);
							step_d     = STEP_TGT;
							state_d    = ST_ADJ_RD;
						end
						default: begin
							rep_addr_d = IW'(req.data.target_cell);
							state_d    = ST_REP_RD;
						end
					endcase
				end
			end
			ST_ADJ_RD: begin
				raddr   = adj_addr_q;
				if ((req_q.req_type != rch_pkg::REQ_CONS) && tgt_null) begin
					res_d.total_refs = total_q;
					state_d          = ST_FIN;
				end else begin
					state_d = ST_ADJ_WR;
				end
			end
			ST_ADJ_WR: begin
				// saturating count change, total follows
				we    = 1'b1;
				waddr = adj_addr_q;
				wdata = rdata;
				if (adj_inc_q) begin
					if (rdata.refs != rch_pkg::REFS_MAX) begin
						wdata.refs = rdata.refs + 1'b1;
						if (total_q != rch_pkg::REFS_MAX) begin
							total_d = total_q + 1'b1;
						end
					end
				end else if (rdata.refs != '0) begin
					wdata.refs = rdata.refs - 1'b1;
					if (total_q != '0) begin
						total_d = total_q - 1'b1;
					end
				end
				case (step_q)
					STEP_TGT: begin
						state_d = ST_REP_RD;
					end
					STEP_MK_H: begin
						if (!mk_tail.nul) begin
							adj_addr_d = IW'(mk_tail.idx);
							adj_inc_d  = 1'b1;
							step_d     = STEP_MK_T;
							state_d    = ST_ADJ_RD;
						end else begin
							go_post_scan = 1'b1;
						end
					end
					STEP_MK_T: begin
						go_post_scan = 1'b1;
					end
					STEP_REL_H: begin
						if (!rel_tail_q.nul) begin
							adj_addr_d = IW'(rel_tail_q.idx);
							adj_inc_d  = 1'b0;
							step_d     = STEP_REL_T;
							state_d    = ST_ADJ_RD;
						end else begin
							go_after_rel = 1'b1;
						end
					end
					default: begin
						go_after_rel = 1'b1;
					end
				endcase
			end
			ST_SCAN: begin
				// one read per cycle; the check trails by the read latency
				raddr = scan_addr_q;
				if (chk_vld_s1 && (rdata.refs == '0)) begin
					found_d = chk_addr_s1;
					if (!rdata.head.nul) begin
						adj_addr_d = IW'(rdata.head.idx);
						adj_inc_d  = 1'b0;
						rel_tail_d = rdata.tail;
						step_d     = STEP_REL_H;
						state_d    = ST_ADJ_RD;
					end else if (!rdata.tail.nul) begin
						adj_addr_d = IW'(rdata.tail.idx);
						adj_inc_d  = 1'b0;
						step_d     = STEP_REL_T;
						state_d    = ST_ADJ_RD;
					end else begin
						state_d = ST_IDLE;
						go_after_rel = 1'b1;
					end
				end else if (scan_left_q != '0) begin
					chk_vld_d   = 1'b1;
					scan_left_d = scan_left_q - 1'b1;
					scan_addr_d = (scan_addr_q == IW'(rch_pkg::CELLS - 1)) ?
					              '0 : scan_addr_q + 1'b1;
				end else if (!chk_vld_s1 || (rdata.refs != '0)) begin
					// nothing free
					slot_ok_d = 1'b0;
					if (pre_q) begin
						res_d.out_of_memory = 1'b1;
						res_d.total_refs    = total_q;
						state_d             = ST_FIN;
					end else begin
						oom_d      = 1'b1;
						rep_addr_d = slot_q;
						state_d    = ST_REP_RD;
					end
				end
			end
			ST_MAKE: begin
				we    = 1'b1;
				waddr = slot_q;
				wdata = '{refs: '0, head: mk_head, tail: mk_tail};
				pre_d = 1'b0;
				if (!mk_head.nul) begin
					adj_addr_d = IW'(mk_head.idx);
					adj_inc_d  = 1'b1;
					step_d     = STEP_MK_H;
					state_d    = ST_ADJ_RD;
				end else if (!mk_tail.nul) begin
					adj_addr_d = IW'(mk_tail.idx);
					adj_inc_d  = 1'b1;
					step_d     = STEP_MK_T;
					state_d    = ST_ADJ_RD;
				end else begin
					go_post_scan = 1'b1;
				end
			end
			ST_REP_RD: begin
				raddr = rep_addr_q;
				if ((req_q.req_type != rch_pkg::REQ_CONS) && tgt_null) begin
					res_d.total_refs = total_q;
					state_d          = ST_FIN;
				end else begin
					state_d = ST_REP_DAT;
				end
			end
			ST_REP_DAT: begin
				res_d.made_cell      = (req_q.req_type == rch_pkg::REQ_CONS) ?
				                       rch_pkg::LINK_W'(rep_addr_q) : '0;
				res_d.out_of_memory  = oom_q;
				res_d.cell_head      = rdata.head.nul ? '0 : rdata.head.idx;
				res_d.cell_head_null = rdata.head.nul;
				res_d.cell_tail      = rdata.tail.nul ? '0 : rdata.tail.idx;
				res_d.cell_tail_null = rdata.tail.nul;
				res_d.cell_refs      = rdata.refs;
				res_d.total_refs     = total_q;
				state_d              = ST_FIN;
			end
			ST_FIN: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// a zero-count cell was found and its children released
		if (go_after_rel) begin
			slot_ok_d = 1'b1;
			slot_d    = found_d;
			if (pre_q) begin
				state_d = ST_MAKE;
			end else begin
				rep_addr_d = slot_q;
				state_d    = ST_REP_RD;
			end
		end

		// search after a cons starts just past the new cell
		if (go_post_scan) begin
			scan_addr_d = (slot_q == IW'(rch_pkg::CELLS - 1)) ? '0 : slot_q + 1'b1;
			scan_left_d = CW'(rch_pkg::CELLS - 1);
			state_d     = ST_SCAN;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			step_q     <= STEP_TGT;
			slot_q     <= '0;
			slot_ok_q  <= 1'b1;
			pre_q      <= 1'b0;
			oom_q      <= 1'b0;
			total_q    <= '0;
			clr_q      <= '0;
			chk_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			step_q     <= step_d;
			slot_q     <= slot_d;
			slot_ok_q  <= slot_ok_d;
			pre_q      <= pre_d;
			oom_q      <= oom_d;
			total_q    <= total_d;
			clr_q      <= clr_d;
			chk_vld_s1 <= chk_vld_d;
			if ((state_q == ST_FIN) && (!out_vld_q || rsp.ready)) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= req.data;
		end
		adj_addr_q  <= adj_addr_d;
		adj_inc_q   <= adj_inc_d;
		rel_tail_q  <= rel_tail_d;
		found_q     <= found_d;
		rep_addr_q  <= rep_addr_d;
		scan_addr_q <= scan_addr_d;
		scan_left_q <= scan_left_d;
		chk_addr_s1 <= scan_addr_q;
		res_q       <= res_d;
		if ((state_q == ST_FIN) && (!out_vld_q || rsp.ready)) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// cell store
	rch_ram #(
		.WIDTH ($bits(rch_pkg::entry_t)),
		.DEPTH (rch_pkg::CELLS)
	) u_cells (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule
`default_nettype wire

FILE: verif/refcount_cell_heap_top_test.sv
`default_nettype none
module refcount_cell_heap_top_test;
	import rch_pkg::*;

	localparam int LIMIT = 60_000_000;

	// heap shadow: counts, links, prepared slot and running total
	class heap_scoreboard;
		logic [REFS_W-1:0] refs [CELLS];
		link_t             heads [CELLS];
		link_t             tails [CELLS];
		int                free_slot;
		bit                slot_ok;
		int                last_made;
		logic [REFS_W-1:0] total;
		rsp_t              pending[$];
		int                errors;

		function void clear();
			for (int i = 0; i < CELLS; i++) begin
				refs[i] = '0;
				heads[i] = LINK_NULL;
				tails[i] = LINK_NULL;
			end
			free_slot = 0;
			slot_ok = 1;
			last_made = CELLS;
			total = '0;
			errors = 0;
		endfunction

		function void bump(link_t l);
			if (l.nul || refs[l.idx] == REFS_MAX)
				return;
			refs[l.idx]++;
			if (total != REFS_MAX)
				total++;
		endfunction

		function void unbump(link_t l);
			if (l.nul || refs[l.idx] == 0)
				return;
			refs[l.idx]--;
			if (total != 0)
				total--;
		endfunction

		// next zero-count cell after the last one made; releases its old children
		function bit find_free();
			int first, span, c;
			first = (last_made >= CELLS) ? 0 : last_made + 1;
			span = (last_made >= CELLS) ? CELLS : CELLS - 1;
			for (int i = 0; i < span; i++) begin
				c = (first + i) % CELLS;
				if (refs[c] == 0) begin
					unbump(heads[c]);
					unbump(tails[c]);
					free_slot = c;
					slot_ok = 1;
					return 1;
				end
			end
			slot_ok = 0;
			return 0;
		endfunction

		function void describe(int c, inout rsp_t r);
			if (c >= CELLS) begin
				r.cell_head_null = 1;
				r.cell_tail_null = 1;
				return;
			end
			r.cell_head = heads[c].idx;
			r.cell_head_null = heads[c].nul;
			r.cell_tail = tails[c].idx;
			r.cell_tail_null = tails[c].nul;
			r.cell_refs = refs[c];
		endfunction

		function void note_request(req_t q);
			rsp_t r;
			link_t h, t;
			int tgt, s;
			r = '0;
			tgt = q.target_null ? CELLS : int'(q.target_cell);
			if (req_code_t'(q.req_type) == REQ_CONS) begin
				h = q.new_head_null ? LINK_NULL : link_t'{1'b0, q.new_head};
				t = q.new_tail_null ? LINK_NULL : link_t'{1'b0, q.new_tail};
				if (!slot_ok && !find_free()) begin
					r.out_of_memory = 1;
					r.cell_head_null = 1;
					r.cell_tail_null = 1;
				end else begin
					s = free_slot;
					last_made = s;
					refs[s] = '0;
					heads[s] = h;
					bump(h);
					tails[s] = t;
					bump(t);
					r.out_of_memory = !find_free();
					r.made_cell = s[LINK_W-1:0];
					describe(s, r);
				end
			end else begin
				if (req_code_t'(q.req_type) == REQ_ADD && tgt < CELLS)
					bump(link_t'{1'b0, q.target_cell});
				else if (req_code_t'(q.req_type) == REQ_DROP && tgt < CELLS)
					unbump(link_t'{1'b0, q.target_cell});
				describe(tgt, r);
			end
			r.total_refs = total;
			pending.push_back(r);
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.made_cell !== e.made_cell) begin
				$error("made_cell exp %0d got %0d", e.made_cell, a.made_cell); errors++;
			end
			if (a.out_of_memory !== e.out_of_memory) begin
				$error("out_of_memory exp %0d got %0d", e.out_of_memory, a.out_of_memory);
				errors++;
			end
			if (a.cell_head !== e.cell_head) begin
				$error("cell_head exp %0d got %0d", e.cell_head, a.cell_head); errors++;
			end
			if (a.cell_head_null !== e.cell_head_null) begin
				$error("cell_head_null exp %0d got %0d", e.cell_head_null, a.cell_head_null);
				errors++;
			end
			if (a.cell_tail !== e.cell_tail) begin
				$error("cell_tail exp %0d got %0d", e.cell_tail, a.cell_tail); errors++;
			end
			if (a.cell_tail_null !== e.cell_tail_null) begin
				$error("cell_tail_null exp %0d got %0d", e.cell_tail_null, a.cell_tail_null);
				errors++;
			end
			if (a.cell_refs !== e.cell_refs) begin
				$error("cell_refs exp %0d got %0d", e.cell_refs, a.cell_refs); errors++;
			end
			if (a.total_refs !== e.total_refs) begin
				$error("total_refs exp %0d got %0d", e.total_refs, a.total_refs); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	rch_req_if req ();
	rch_rsp_if rsp ();
	heap_scoreboard sb;
	bit calm;
	int cycles;

	refcount_cell_heap_top dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #5 clk = ~clk;

	initial begin
		req.valid = 0;
		req.data = '0;
		rsp.ready = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: accept, check, stall in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.data);
		end
	end

	initial begin : sink_ready
		int n;
		@(posedge arst_n);
		forever begin
			rsp.ready <= 1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 1)) begin
				rsp.ready <= 0;
				n = $urandom_range(1, 15);
				repeat (n) @(posedge clk);
			end
		end
	end

	// one word, sometimes with a random gap before it
	task automatic send(req_t q);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req.data <= q;
		req.valid <= 1;
		do @(posedge clk); while (!req.ready);
		sb.note_request(q);
	endtask

	function automatic req_t mk(req_code_t op, int tgt, bit tn, int h, bit hn,
		int t, bit tln);
		req_t q;
		q.req_type = op;
		q.target_cell = LINK_W'(tgt);
		q.target_null = tn;
		q.new_head = LINK_W'(h);
		q.new_head_null = hn;
		q.new_tail = LINK_W'(t);
		q.new_tail_null = tln;
		return q;
	endfunction

	// mostly small indices so links land on live cells
	function automatic int pick_cell();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, CELLS - 1)
			: $urandom_range(0, 63);
	endfunction

	task automatic drain();
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		req_t q;
		int r;
		sb = new();
		sb.clear();
		cycles = 0;
		calm = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every request, null and stale cases
		send(mk(REQ_READ, 0, 0, 0, 0, 0, 0));
		send(mk(REQ_CONS, 0, 0, 0, 1, 4095, 1));
		send(mk(REQ_CONS, 4095, 1, 0, 0, 4095, 0));
		send(mk(REQ_CONS, 0, 0, 1, 0, 1, 0));
		send(mk(REQ_ADD, 4095, 0, 0, 0, 0, 0));
		send(mk(REQ_ADD, 7, 1, 0, 0, 0, 0));
		send(mk(REQ_DROP, 7, 1, 0, 0, 0, 0));
		send(mk(REQ_DROP, 100, 0, 0, 0, 0, 0));
		send(mk(REQ_READ, 4095, 0, 0, 0, 0, 0));
		send(mk(REQ_READ, 4095, 1, 0, 0, 0, 0));
		// prepared slot raised by adds before a cons
		send(mk(REQ_ADD, sb.free_slot, 0, 0, 0, 0, 0));
		send(mk(REQ_ADD, sb.free_slot, 0, 0, 0, 0, 0));
		send(mk(REQ_CONS, 0, 0, 2, 0, 2, 0));
		// drop to zero, stale links stay until chosen
		send(mk(REQ_DROP, 2, 0, 0, 0, 0, 0));
		send(mk(REQ_DROP, 2, 0, 0, 0, 0, 0));
		send(mk(REQ_READ, 2, 0, 0, 0, 0, 0));
		send(mk(REQ_CONS, 0, 0, 5, 1, 6, 1));
		send(mk(REQ_READ, 1, 0, 0, 0, 0, 0));
		// pause until every result is back
		drain();

		// random: mostly small indices, some full-range and null
		for (int i = 0; i < 1800; i++) begin
			if (i == 1500)
				calm = 1;
			r = $urandom_range(0, 9);
			q = mk(r < 3 ? REQ_CONS : r < 6 ? REQ_ADD : r < 8 ? REQ_DROP : REQ_READ,
				pick_cell(), $urandom_range(0, 15) == 0,
				pick_cell(), $urandom_range(0, 5) == 0,
				pick_cell(), $urandom_range(0, 5) == 0);
			send(q);
		end

		// forty adds on cell 4095, then wait for every result
		for (int i = 0; i < 40; i++)
			send(mk(REQ_ADD, 4095, 0, 0, 0, 0, 0));
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (5000) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
